### src/reb_pkg.sv
// Shared types and constants for the rotary encoder and button event unit.
package reb_pkg;

    localparam int unsigned TimeW    = 32;
    localparam int unsigned HoldW    = 16;
    localparam int unsigned CfgIdxW  = 1;
    localparam int unsigned CfgDataW = 16;

    localparam logic [HoldW-1:0] LongPressReset = 16'd1500;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgLongPressMs   = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgHandlerEnable = 1'd1;

    // mode code that no event kind uses
    localparam logic [1:0] ModeUnused = 2'd3;

    typedef enum logic [1:0] {
        MODE_ENCODER = 2'd0,
        MODE_BUTTON  = 2'd1,
        MODE_TICK    = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_CW   = 2'd1,
        PHASE_CCW  = 2'd2
    } t_phase;

    typedef struct packed {
        logic       mode_unused;
        t_mode      mode;
        logic       enc_a;
        logic       enc_b;
        logic       button_level;
        logic [TimeW-1:0] now_ms;
    } t_event;

    typedef struct packed {
        logic turn_right;
        logic turn_left;
        logic short_press;
        logic hold_press;
    } t_result;

endpackage

### src/reb_core.sv
// Event decode state: detent decoder, button tracking and tick reporting.
module reb_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  reb_pkg::t_event               i_event,
    input  logic [reb_pkg::HoldW-1:0]     i_hold_ms,
    input  logic                          i_handler_enabled,
    output reb_pkg::t_result              o_result
);

    reb_pkg::t_phase             r_phase, n_phase;
    logic                        r_pend_right, n_pend_right;
    logic                        r_pend_left, n_pend_left;
    logic                        r_pend_press, n_pend_press;
    logic                        r_held, n_held;
    logic [reb_pkg::TimeW-1:0]   r_press_time, n_press_time;

    logic [reb_pkg::TimeW-1:0]   elapsed;
    logic                        expired;
    reb_pkg::t_phase             cur_phase;

    assign elapsed = i_event.now_ms - r_press_time;
    assign expired = elapsed > {{(reb_pkg::TimeW-reb_pkg::HoldW){1'b0}}, i_hold_ms};

    always_comb begin
        // the unused phase code reads as idle
        cur_phase    = (r_phase == reb_pkg::PHASE_CW || r_phase == reb_pkg::PHASE_CCW)
                       ? r_phase : reb_pkg::PHASE_IDLE;
        n_phase      = r_phase;
        n_pend_right = r_pend_right;
        n_pend_left  = r_pend_left;
        n_pend_press = r_pend_press;
        n_held       = r_held;
        n_press_time = r_press_time;
        o_result     = '0;
        if (!i_event.mode_unused) begin
            unique case (i_event.mode)
                reb_pkg::MODE_ENCODER: begin
                    n_phase = cur_phase;
                    if (!i_event.enc_a) begin
                        n_phase = i_event.enc_b ? reb_pkg::PHASE_CW : reb_pkg::PHASE_CCW;
                    end else if (cur_phase == reb_pkg::PHASE_CW && !i_event.enc_b) begin
                        n_pend_right = 1'b1;
                        n_phase      = reb_pkg::PHASE_IDLE;
                    end else if (cur_phase == reb_pkg::PHASE_CCW && i_event.enc_b) begin
                        n_pend_left = 1'b1;
                        n_phase     = reb_pkg::PHASE_IDLE;
                    end
                end
                reb_pkg::MODE_BUTTON: begin
                    n_press_time = i_event.now_ms;
                    if (!i_event.button_level) begin
                        n_held = 1'b1;
                    end else if (r_held) begin
                        n_pend_press = 1'b1;
                        n_held       = 1'b0;
                    end
                end
                reb_pkg::MODE_TICK: begin
                    o_result.turn_right  = i_handler_enabled & r_pend_right;
                    o_result.turn_left   = i_handler_enabled & r_pend_left;
                    o_result.short_press = i_handler_enabled & r_pend_press;
                    n_pend_right = 1'b0;
                    n_pend_left  = 1'b0;
                    n_pend_press = 1'b0;
                    if (r_held && expired) begin
                        o_result.hold_press = i_handler_enabled & ~i_event.button_level;
                        n_held = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= reb_pkg::PHASE_IDLE;
            r_pend_right <= 1'b0;
            r_pend_left  <= 1'b0;
            r_pend_press <= 1'b0;
            r_held       <= 1'b0;
            r_press_time <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_pend_right <= n_pend_right;
            r_pend_left  <= n_pend_left;
            r_pend_press <= n_pend_press;
            r_held       <= n_held;
            r_press_time <= n_press_time;
        end
    end

endmodule

### src/rotary_encoder_button_events_unit.sv
// Top level of the rotary encoder and button event unit.
// Path: an event passes through the input register, then the result register.
// Throughput: one event per cycle while the consumer does not stall; the input
//   register can still take one event while a finished result waits for the consumer.
// Reset (i_rst_n low, synchronous): pipeline empty, decoder idle, flags clear,
//   hold time 1500 ms, handler detached.
module rotary_encoder_button_events_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // event channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_mode,
    input  logic                            i_enc_a,
    input  logic                            i_enc_b,
    input  logic                            i_button_level,
    input  logic [reb_pkg::TimeW-1:0]       i_now_ms,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_turn_right,
    output logic                            o_turn_left,
    output logic                            o_short_press,
    output logic                            o_hold_press,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [reb_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [reb_pkg::CfgDataW-1:0]    i_cfg_data
);

    logic [reb_pkg::HoldW-1:0] r_hold_ms;
    logic                      r_handler_enabled;

    logic                      r_in_valid;
    reb_pkg::t_event           r_event;
    logic                      r_out_valid;
    reb_pkg::t_result          r_result;
    reb_pkg::t_result          result;

    logic                      fire;
    logic                      in_xfer;

    // Advance the held event into the result register whenever that slot is
    // empty or being drained this cycle; the decoder state commits on the
    // same edge.
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Configuration: plain write port, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ms         <= reb_pkg::LongPressReset;
            r_handler_enabled <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                reb_pkg::CfgLongPressMs:   r_hold_ms         <= i_cfg_data;
                reb_pkg::CfgHandlerEnable: r_handler_enabled <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register: hold the event while the result side backs up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            // mode code three is unused; flag it so the core drops the event
            r_event.mode_unused  <= (i_mode == reb_pkg::ModeUnused);
            r_event.mode         <= reb_pkg::t_mode'(i_mode);
            r_event.enc_a        <= i_enc_a;
            r_event.enc_b        <= i_enc_b;
            r_event.button_level <= i_button_level;
            r_event.now_ms       <= i_now_ms;
        end
    end

    reb_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (fire),
        .i_event           (r_event),
        .i_hold_ms         (r_hold_ms),
        .i_handler_enabled (r_handler_enabled),
        .o_result          (result)
    );

    // Result register: one result per event, every field zero except on ticks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_turn_right  = r_result.turn_right;
    assign o_turn_left   = r_result.turn_left;
    assign o_short_press = r_result.short_press;
    assign o_hold_press  = r_result.hold_press;

endmodule

### test/rotary_encoder_button_events_unit_tb.sv
// Self-checking testbench for the rotary encoder and button event unit.
`timescale 1ns / 100ps

module rotary_encoder_button_events_unit_tb;

    // Short names for the codes used in the directed table.
    localparam logic [1:0] MdEnc  = reb_pkg::MODE_ENCODER;
    localparam logic [1:0] MdBtn  = reb_pkg::MODE_BUTTON;
    localparam logic [1:0] MdTick = reb_pkg::MODE_TICK;
    localparam logic [1:0] MdNone = reb_pkg::ModeUnused;
    localparam logic [reb_pkg::CfgIdxW-1:0] IdxHold = reb_pkg::CfgLongPressMs;
    localparam logic [reb_pkg::CfgIdxW-1:0] IdxHook = reb_pkg::CfgHandlerEnable;

    // Margin after the pipeline empties; used before config writes, now and then, and at the end.
    localparam int DrainCycles   = 6;
    // Cycles without any transfer before the run is declared hung.
    localparam int WatchdogLimit = 1000;
    localparam int SegItems      = 292;

    localparam reb_pkg::t_result NoReport = '0;

    typedef enum bit {
        ROW_EVENT,
        ROW_CFG
    } t_row_kind;

    // One row of the directed table: either a register write or an event transfer.
    typedef struct packed {
        t_row_kind                    kind;
        logic [reb_pkg::CfgIdxW-1:0]  idx;
        logic [reb_pkg::CfgDataW-1:0] data;
        logic [1:0]                   md;
        logic                         a;
        logic                         b;
        logic                         lvl;
        logic [reb_pkg::TimeW-1:0]    now;
        bit                           typed;
        reb_pkg::t_result             exp;
    } t_step_row;

    // Rows with typed=1 carry a result that is plain from the spec (handler
    // detached, unused mode); the rest are checked against the decoder model.
    localparam t_step_row DirRows [27] = '{
        // handler detached after reset: every report reads zero
        '{ROW_EVENT, IdxHold, 16'd0, MdTick, 1'b0, 1'b0, 1'b1, 32'd0,
          1'b1, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdEnc,  1'b0, 1'b1, 1'b1, 32'd0,
          1'b1, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdEnc,  1'b1, 1'b0, 1'b1, 32'd0,
          1'b1, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdBtn,  1'b0, 1'b0, 1'b0, 32'd100,
          1'b1, NoReport},
        // hold expired while detached: flags and held state still cleared
        '{ROW_EVENT, IdxHold, 16'd0, MdTick, 1'b0, 1'b0, 1'b0, 32'd1700,
          1'b1, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdBtn,  1'b0, 1'b0, 1'b1, 32'd1800,
          1'b1, NoReport},
        '{ROW_CFG,   IdxHook, 16'd1, MdEnc,  1'b0, 1'b0, 1'b0, 32'd0,
          1'b0, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdTick, 1'b0, 1'b0, 1'b1, 32'd1900,
          1'b0, NoReport},
        // counter-clockwise detent, a stray edge while idle, then a clockwise one
        '{ROW_EVENT, IdxHold, 16'd0, MdEnc,  1'b0, 1'b0, 1'b1, 32'd0,
          1'b0, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdEnc,  1'b1, 1'b1, 1'b1, 32'd0,
          1'b0, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdEnc,  1'b1, 1'b1, 1'b1, 32'd0,
          1'b0, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdEnc,  1'b0, 1'b1, 1'b1, 32'd0,
          1'b0, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdEnc,  1'b1, 1'b0, 1'b1, 32'd0,
          1'b0, NoReport},
        // short press across the time wrap, then one tick reports all three flags
        '{ROW_EVENT, IdxHold, 16'd0, MdBtn,  1'b1, 1'b1, 1'b0, 32'hFFFF_FFF0,
          1'b0, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdBtn,  1'b0, 1'b0, 1'b1, 32'h0000_0010,
          1'b0, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdTick, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF,
          1'b0, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdNone, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF,
          1'b1, NoReport},
        '{ROW_CFG,   IdxHold, 16'hFFFF, MdEnc, 1'b0, 1'b0, 1'b0, 32'd0,
          1'b0, NoReport},
        // longest hold: equal is not enough, one past with line high is dropped
        '{ROW_EVENT, IdxHold, 16'd0, MdBtn,  1'b0, 1'b0, 1'b0, 32'hFFFF_0000,
          1'b0, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdTick, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF,
          1'b0, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdTick, 1'b0, 1'b0, 1'b1, 32'd0,
          1'b0, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdBtn,  1'b0, 1'b0, 1'b0, 32'd5,
          1'b0, NoReport},
        '{ROW_CFG,   IdxHold, 16'd0, MdEnc,  1'b0, 1'b0, 1'b0, 32'd0,
          1'b0, NoReport},
        // zero hold: same ms is not a long press, the next ms is
        '{ROW_EVENT, IdxHold, 16'd0, MdTick, 1'b0, 1'b0, 1'b0, 32'd5,
          1'b0, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdTick, 1'b0, 1'b0, 1'b0, 32'd6,
          1'b0, NoReport},
        // release after a long press latches no short press
        '{ROW_EVENT, IdxHold, 16'd0, MdBtn,  1'b0, 1'b0, 1'b1, 32'd7,
          1'b0, NoReport},
        '{ROW_EVENT, IdxHold, 16'd0, MdTick, 1'b0, 1'b0, 1'b1, 32'd8,
          1'b0, NoReport}
    };

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [1:0]                   i_mode;
    logic                         i_enc_a;
    logic                         i_enc_b;
    logic                         i_button_level;
    logic [reb_pkg::TimeW-1:0]    i_now_ms;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic                         o_turn_right;
    logic                         o_turn_left;
    logic                         o_short_press;
    logic                         o_hold_press;
    logic                         i_cfg_we;
    logic [reb_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [reb_pkg::CfgDataW-1:0] i_cfg_data;

    // Decoder model state and its copy of the registers.
    reb_pkg::t_phase           enc_phase;
    bit                        got_right;
    bit                        got_left;
    bit                        got_click;
    bit                        btn_down;
    logic [reb_pkg::TimeW-1:0] press_at;
    logic [reb_pkg::HoldW-1:0] hold_ms;
    bit                        hook_on;

    // Reports still owed by the unit, oldest first.
    reb_pkg::t_result reports_due [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int idle_cycles;
    int result_idx;

    // Bit i of t_result carries field_label[i].
    string field_label [4] = '{"hold_press", "short_press", "turn_left", "turn_right"};

    rotary_encoder_button_events_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_enc_a        (i_enc_a),
        .i_enc_b        (i_enc_b),
        .i_button_level (i_button_level),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_turn_right   (o_turn_right),
        .o_turn_left    (o_turn_left),
        .o_short_press  (o_short_press),
        .o_hold_press   (o_hold_press),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advance the decoder model by one event and return the report it owes.
    function automatic reb_pkg::t_result decode_event(input logic [1:0] md, input logic a,
                                                      input logic b, input logic lvl,
                                                      input logic [reb_pkg::TimeW-1:0] now);
        reb_pkg::t_result          rep;
        logic [reb_pkg::TimeW-1:0] since;
        rep = NoReport;
        case (md)
            MdEnc: begin
                // A low arms a direction by B; A high with the opposite B ends the detent.
                if (!a) begin
                    enc_phase = b ? reb_pkg::PHASE_CW : reb_pkg::PHASE_CCW;
                end else if (enc_phase == reb_pkg::PHASE_CW && !b) begin
                    got_right = 1'b1;
                    enc_phase = reb_pkg::PHASE_IDLE;
                end else if (enc_phase == reb_pkg::PHASE_CCW && b) begin
                    got_left  = 1'b1;
                    enc_phase = reb_pkg::PHASE_IDLE;
                end
            end
            MdBtn: begin
                press_at = now;
                if (!lvl) begin
                    btn_down = 1'b1;
                end else if (btn_down) begin
                    got_click = 1'b1;
                    btn_down  = 1'b0;
                end
            end
            MdTick: begin
                since           = now - press_at;
                rep.turn_right  = hook_on & got_right;
                rep.turn_left   = hook_on & got_left;
                rep.short_press = hook_on & got_click;
                got_right       = 1'b0;
                got_left        = 1'b0;
                got_click       = 1'b0;
                // Report the long press only with the line still low; drop the hold either way.
                if (btn_down && since > {{(reb_pkg::TimeW-reb_pkg::HoldW){1'b0}}, hold_ms}) begin
                    rep.hold_press = hook_on & ~lvl;
                    btn_down       = 1'b0;
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Present one event, hold it through stalls, and log its report at transfer.
    task automatic send_event(input logic [1:0] md, input logic a, input logic b,
                              input logic lvl, input logic [reb_pkg::TimeW-1:0] now,
                              input bit typed, input reb_pkg::t_result exp);
        reb_pkg::t_result due;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= md;
        i_enc_a        <= a;
        i_enc_b        <= b;
        i_button_level <= lvl;
        i_now_ms       <= now;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        due = decode_event(md, a, b, lvl, now);
        reports_due.push_back(typed ? exp : due);
    endtask

    // Stop sending and wait until every owed report has come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (reports_due.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [reb_pkg::CfgIdxW-1:0] idx,
                             input logic [reb_pkg::CfgDataW-1:0] data);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == reb_pkg::CfgLongPressMs)
            hold_ms = data;
        else
            hook_on = data[0];
    endtask

    // Receiver side: stall at the rate of the current idling pattern.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check every result transfer against the oldest owed report; watch for a hang.
    always @(posedge i_clk) begin : result_check
        reb_pkg::t_result got;
        reb_pkg::t_result want;
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WatchdogLimit) begin
                    $display("%0t ns watchdog: no transfer for %0d cycles", $time, idle_cycles);
                    $display("Some tests failed");
                    $finish;
                end
            end
            if (o_out_valid && !i_out_stall) begin
                got = {o_turn_right, o_turn_left, o_short_press, o_hold_press};
                if (reports_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d (%b) with nothing owed",
                                              result_idx, got));
                end else begin
                    want = reports_due.pop_front();
                    for (int f = 0; f < 4; f++) begin
                        if (got[f] !== want[f])
                            report_mismatch($sformatf("result %0d %s got %b want %b",
                                                      result_idx, field_label[f],
                                                      got[f], want[f]));
                    end
                end
                result_idx++;
            end
        end
    end

    initial begin : stimulus
        int                        seg;
        int                        made;
        int                        roll;
        int unsigned               span;
        bit                        dir;
        bit                        line_down;
        logic [reb_pkg::TimeW-1:0] clock_ms;
        logic [31:0]               junk;

        // Drive every input to a known value while reset is held low.
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_mode         <= MdEnc;
        i_enc_a        <= 1'b0;
        i_enc_b        <= 1'b0;
        i_button_level <= 1'b1;
        i_now_ms       <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= IdxHold;
        i_cfg_data     <= '0;

        enc_phase     = reb_pkg::PHASE_IDLE;
        got_right     = 1'b0;
        got_left      = 1'b0;
        got_click     = 1'b0;
        btn_down      = 1'b0;
        press_at      = '0;
        hold_ms       = reb_pkg::LongPressReset;
        hook_on       = 1'b0;
        mismatches    = 0;
        idle_cycles   = 0;
        result_idx    = 0;
        send_idle_pct = 34;
        recv_idle_pct = 77;
        line_down     = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table.
        foreach (DirRows[r]) begin
            if (DirRows[r].kind == ROW_CFG)
                write_reg(DirRows[r].idx, DirRows[r].data);
            else
                send_event(DirRows[r].md, DirRows[r].a, DirRows[r].b, DirRows[r].lvl,
                           DirRows[r].now, DirRows[r].typed, DirRows[r].exp);
        end

        // Random part: six segments, two per idling pattern, each with fresh registers.
        clock_ms = $urandom;
        for (seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle_pct = 34;
                    recv_idle_pct = 77;
                end
                1: begin
                    send_idle_pct = 77;
                    recv_idle_pct = 34;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            junk = $urandom;
            write_reg(IdxHold, (seg == 3) ? 16'hFFFF : 16'($urandom_range(150)));
            write_reg(IdxHook, {junk[14:0], seg != 1});
            // Step time so that presses land on both sides of the hold limit.
            span = (hold_ms > 400) ? 100 : 32'(int'(hold_ms) / 3 + 4);

            made = 0;
            while (made < SegItems) begin
                roll = $urandom_range(99);
                if ($urandom_range(49) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms += $urandom_range(span);

                if (roll < 35) begin
                    // Full detent, bounced back now and then.
                    dir = 1'($urandom_range(1));
                    send_event(MdEnc, 1'b0, dir, 1'($urandom_range(1)), clock_ms,
                               1'b0, NoReport);
                    send_event(MdEnc, 1'b1, ($urandom_range(9) == 0) ? dir : ~dir,
                               1'($urandom_range(1)), clock_ms, 1'b0, NoReport);
                    made += 2;
                end else if (roll < 50) begin
                    line_down = 1'b1;
                    send_event(MdBtn, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0,
                               clock_ms, 1'b0, NoReport);
                    made++;
                end else if (roll < 62) begin
                    line_down = 1'b0;
                    send_event(MdBtn, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1,
                               clock_ms, 1'b0, NoReport);
                    made++;
                end else if (roll < 90) begin
                    // Tick mostly sees the true line level, sometimes a glitch.
                    send_event(MdTick, 1'($urandom_range(1)), 1'($urandom_range(1)),
                               ($urandom_range(9) == 0) ? 1'($urandom_range(1)) : ~line_down,
                               clock_ms, 1'b0, NoReport);
                    made++;
                end else if (roll < 97) begin
                    send_event(MdEnc, 1'($urandom_range(1)), 1'($urandom_range(1)),
                               1'($urandom_range(1)), clock_ms, 1'b0, NoReport);
                    made++;
                end else begin
                    // Ignored by the unit; not counted.
                    send_event(MdNone, 1'($urandom_range(1)), 1'($urandom_range(1)),
                               1'($urandom_range(1)), $urandom, 1'b1, NoReport);
                end

                // Hold off now and then until the unit has caught up.
                if ($urandom_range(299) == 0)
                    drain_results();
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
src/reb_pkg.sv
src/reb_core.sv
src/rotary_encoder_button_events_unit.sv
test/rotary_encoder_button_events_unit_tb.sv
